>>> rtl/core/sha256_pkg.sv
package sha256_pkg;

   localparam int unsigned BlockBytes  = 64;
   localparam int unsigned RoundCount  = 64;
   localparam int unsigned DigestWords = 8;

   typedef logic [31:0] word_type;

   // Control handed from the sequencer to the round unit.
   typedef struct packed {
      logic       load;      // copy chain words into the working variables
      logic       round_en;  // run one round
      logic [5:0] round_idx; // round number
      logic       fold;      // add working variables into the chain words
      logic       chain_rst; // restore the initial hash values
   } round_ctl_type;

   function automatic word_type init_chain(input logic [2:0] idx);
      word_type r;
      case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic word_type round_const(input logic [5:0] idx);
      word_type r;
      case (idx)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

   function automatic word_type ror32(input word_type x, input int unsigned s);
      return (x >> s) | (x << (32 - s));
   endfunction

endpackage

>>> rtl/core/sha256_if.sv
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;
   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_position;
   logic        last_word;
   modport source (output valid, digest_word, word_position, last_word, input ready);
   modport sink   (input valid, digest_word, word_position, last_word, output ready);
endinterface

>>> rtl/core/sha256_round.sv
module sha256_round
   import sha256_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  round_ctl_type ctl,
   input  word_type      msg_word,    // block word for rounds 0..15
   input  logic [2:0]    rd_idx,
   output word_type      chain_word
);

   word_type chain_ff [DigestWords];
   word_type var_ff   [DigestWords];
   word_type sched_ff [16];

   word_type w_in, x15, x2, s0, s1, t1, t2;
   logic [3:0] slot;

   assign slot = ctl.round_idx[3:0];
   assign x15  = sched_ff[slot + 4'd1];
   assign x2   = sched_ff[slot + 4'd14];

   // Message schedule expansion and the round function.
   always_comb begin
      s0 = ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3);
      s1 = ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10);
      if (ctl.round_idx < 6'd16) begin
         w_in = msg_word;
      end else begin
         w_in = sched_ff[slot] + s0 + sched_ff[slot + 4'd9] + s1;
      end
      t1 = var_ff[7] + (ror32(var_ff[4], 6) ^ ror32(var_ff[4], 11) ^ ror32(var_ff[4], 25))
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
         + round_const(ctl.round_idx) + w_in;
      t2 = (ror32(var_ff[0], 2) ^ ror32(var_ff[0], 13) ^ ror32(var_ff[0], 22))
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   end

   // Working variables and schedule window.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < DigestWords; i++) var_ff[i] <= chain_ff[i];
      end else if (ctl.round_en) begin
         sched_ff[slot] <= w_in;
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   // Chaining words.
   always_ff @(posedge clock) begin
      if (reset || ctl.chain_rst) begin
         for (int i = 0; i < DigestWords; i++) chain_ff[i] <= init_chain(3'(i));
      end else if (ctl.fold) begin
         for (int i = 0; i < DigestWords; i++) chain_ff[i] <= chain_ff[i] + var_ff[i];
      end
   end

   assign chain_word = chain_ff[rd_idx];

endmodule

>>> rtl/core/sha256_stream_hasher_unit.sv
// Channel | Dir | Fields
// req_    | in  | data_byte[7:0], has_byte, end_of_message
// rsp_    | out | digest_word[31:0], word_position[2:0], last_word
//
// A byte transaction writes one byte into the block buffer. The 64th byte of a block starts a compression
// of a load step, 64 rounds (one per cycle, single round unit) and a fold step;
// no new byte is taken while a block is being compressed.
// An end transaction pads a byte per cycle to the block end and runs one or two compressions.
// It then shows eight digest transactions and takes a step restoring the initial state;
// req_ready is low throughout. Synchronous reset restores the initial hash values, and
// rsp_ready stalls hold the offered word.
module sha256_stream_hasher_unit
   import sha256_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_FOLD  = 7'b0001000,
      ST_PAD   = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_CLR   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;
   logic        fin_ff, fin_in;   // message end seen; padding in progress
   logic        lenb_ff, lenb_in; // 0x80 byte already written
   logic        late_ff, late_in; // 0x80 byte landed past position 55 in this block
   logic [2:0]  pos_ff, pos_in;
   word_type    buf_ff [BlockBytes / 4];
   logic        wr_en;
   logic [7:0]  wr_byte, pad_byte;
   word_type    msg_word, chain_word;
   round_ctl_type ctl;

   // The block buffer holds big-endian words, so a round reads one entry.
   assign msg_word = buf_ff[round_ff[3:0]];

   sha256_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .msg_word(msg_word),
      .rd_idx(pos_ff), .chain_word(chain_word)
   );

   // Padding byte: 0x80, zeros, then the length bytes at positions 56..63.
   // A block whose 0x80 came late carries zeros to its end instead of the length.
   always_comb begin
      if (!lenb_ff) begin
         pad_byte = 8'h80;
      end else if (fill_ff >= 6'd56 && !late_ff) begin
         pad_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      fin_in   = fin_ff;
      lenb_in  = lenb_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      wr_byte  = req.data_byte;
      ctl      = '0;
      ctl.round_idx = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.has_byte) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
               end
               fin_in = req.end_of_message;
               if (req.has_byte && fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wr_en   = 1'b1;
            wr_byte = pad_byte;
            lenb_in = 1'b1;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.round_en = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(RoundCount - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (lenb_ff && !late_ff) begin
               // The block just folded carried the length.
               state_in = ST_OUT;
               pos_in   = '0;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               pos_in = pos_ff + 3'd1;
               if (pos_ff == 3'd7) state_in = ST_CLR;
            end
         end
         ST_CLR: begin
            ctl.chain_rst = 1'b1;
            fill_in  = '0;
            bits_in  = '0;
            fin_in   = 1'b0;
            lenb_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A 0x80 written past position 55 leaves no room for the length in this block.
   always_comb begin
      late_in = late_ff;
      if (state_ff == ST_PAD && !lenb_ff) late_in = (fill_ff >= 6'd56);
      if (state_ff == ST_FOLD) late_in = 1'b0;
      if (state_ff == ST_CLR) late_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         bits_ff    <= '0;
         round_ff   <= '0;
         fin_ff     <= 1'b0;
         lenb_ff    <= 1'b0;
         pos_ff     <= '0;
         late_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         round_ff   <= round_in;
         fin_ff     <= fin_in;
         lenb_ff    <= lenb_in;
         pos_ff     <= pos_in;
         late_ff    <= late_in;
      end
   end

   // Block buffer; each byte goes into its lane of a big-endian word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = (state_ff == ST_OUT);
   assign rsp.digest_word   = chain_word;
   assign rsp.word_position = pos_ff;
   assign rsp.last_word     = (pos_ff == 3'd7);

endmodule
